>>> src/assert_macros.svh
// Assertion helper macros for the timestamp sample matcher.
// Included by modules that carry assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NTSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ntsm assertion failed");
// Condition must never be true outside reset.
`define NTSM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ntsm forbidden condition seen");
`else
`define NTSM_ASSERT(lbl, clk, rst_n, prop)
`define NTSM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> src/ntsm_pkg.sv
// Shared types and constants for the timestamp sample matcher.
// No dependencies.
`timescale 1ns / 1ps
package ntsm_pkg;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned PRES_W         = 16;
  localparam int unsigned WIN_W          = 8;
  localparam int unsigned WORD_W         = TIME_W + PRES_W;
  localparam int unsigned FIFO_DEPTH_DEF = 128;
  localparam int unsigned QBITS          = 14;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [PRES_W-1:0] AXIS_MIN_RST = 16'd0;
  localparam logic [PRES_W-1:0] AXIS_MAX_RST = 16'd1023;
  localparam logic [WIN_W-1:0]  WINDOW_RST   = 8'd24;
  localparam logic [15:0]       Q_ONE        = 16'sd16384;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_MIN = 2'd0,
    CFG_AXIS_MAX = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } state_e;
endpackage

>>> src/ntsm_store.sv
// Sample memory: one write port, one read port, registered read data.
// Depends on ntsm_pkg for the word width.
`timescale 1ns / 1ps
module ntsm_store #(
  parameter int unsigned DEPTH = ntsm_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [ntsm_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [ntsm_pkg::WORD_W-1:0] rdata_o
);
  import ntsm_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

>>> src/ntsm_div.sv
// Restoring divider: QBITS-bit fraction of num/den, one bit per cycle.
// Requires num < den. Depends on ntsm_pkg.
`timescale 1ns / 1ps
module ntsm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ntsm_pkg::PRES_W-1:0] num_i,
  input  logic [ntsm_pkg::PRES_W-1:0] den_i,
  output logic                        done_o,
  output logic [ntsm_pkg::QBITS-1:0]  quot_o
);
  import ntsm_pkg::*;

  localparam int unsigned CW = $clog2(QBITS + 1);

  logic              run_q, run_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PRES_W-1:0] rem_q, rem_d;
  logic [PRES_W-1:0] den_q, den_d;
  logic [QBITS-1:0]  quot_q, quot_d;
  logic [PRES_W:0]   shifted;
  logic              fits;

  // one shift-subtract step per cycle
  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = shifted >= {1'b0, den_q};
    run_d   = run_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    done_o  = 1'b0;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
    end else if (run_q) begin
      rem_d  = fits ? PRES_W'(shifted - {1'b0, den_q}) : shifted[PRES_W-1:0];
      quot_d = {quot_q[QBITS-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CW'(QBITS - 1)) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_d;
endmodule

>>> src/nearest_timestamp_sample_matcher.sv
// Top level of the nearest timestamp sample matcher.
// Depends on ntsm_pkg, ntsm_store, ntsm_div and assert_macros.svh.
//
// Usage:
//   A word is taken at a clock edge with start high and busy low. Action push
//   stores (stamp_ms_i, raw_pressure_i) in the ring, dropping the oldest sample
//   when full; push, clear and the unused code leave busy low and give no
//   result, so they may follow each other every cycle.
//   A query reads the stored samples oldest first, one memory read a cycle,
//   and keeps the one with the smallest wrapped time difference. Its result
//   word is on matched_o/pressure_value_o while done_o is high for one cycle.
//   A query runs the restoring divider only when a sample matched and its
//   value lies strictly inside the axis range; busy stays high throughout.
//   The receiver cannot stall; a result must be taken in its done_o cycle.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once; indexes
//   past the register list are ignored.
//   Reset empties the ring and loads the register defaults; memory contents
//   are not cleared, only counted entries are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nearest_timestamp_sample_matcher #(
  parameter int unsigned FIFO_DEPTH = ntsm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action_i,
  input  logic [ntsm_pkg::TIME_W-1:0]     stamp_ms_i,
  input  logic [ntsm_pkg::PRES_W-1:0]     raw_pressure_i,
  input  logic                            cfg_we_i,
  input  logic [ntsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic                            matched_o,
  output logic signed [15:0]              pressure_value_o
);
  import ntsm_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CNTW = AW + 1;
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(FIFO_DEPTH);

  state_e state_q, state_d;

  logic [PRES_W-1:0] min_q, max_q;
  logic [WIN_W-1:0]  win_q;

  logic [AW-1:0]   oldest_q, oldest_d;
  logic [CNTW-1:0] fill_q, fill_d;

  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [CNTW-1:0]   issue_q, issue_d;
  logic [AW-1:0]     rslot_q, rslot_d;

  // scan pipeline: read data stage, age stage
  logic              v1_q, v2_q;
  logic [AW-1:0]     idx1_q, idx2_q;
  logic [TIME_W-1:0] age2_q;
  logic [PRES_W-1:0] pres2_q;

  logic              found_q, found_d;
  logic [TIME_W-1:0] best_age_q, best_age_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [PRES_W-1:0] best_pres_q, best_pres_d;

  logic              res_match_q, res_match_d;
  logic [15:0]       res_val_q, res_val_d;
  logic              neg_q, neg_d;

  logic              accept, issue;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_rdata;
  logic [TIME_W-1:0] diff, age;
  logic [CNTW-1:0]   sum;
  logic              hit;
  logic signed [18:0] n_val, d_val;
  logic [18:0]       n_mag;
  logic              div_start, div_done;
  logic [QBITS-1:0]  quot;
  logic [PRES_W-1:0] div_num, div_den;

  assign accept = start && !busy;
  assign issue  = (state_q == ST_SCAN) && (issue_q < fill_q);

  // sample memory
  ntsm_store #(.DEPTH(FIFO_DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({stamp_ms_i, raw_pressure_i}),
    .re_i    (issue),
    .raddr_i (rslot_q),
    .rdata_o (mem_rdata)
  );

  // normalization divider
  ntsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // wrapped age of the word coming out of memory
  assign diff = mem_rdata[WORD_W-1:PRES_W] - stamp_q;
  assign age  = diff[TIME_W-1] ? (~diff + 1'b1) : diff;

  // decision arithmetic
  assign hit   = found_q && (best_age_q <= {{(TIME_W-WIN_W){1'b0}}, win_q});
  assign n_val = $signed({2'b0, best_pres_q, 1'b0}) - $signed({3'b0, min_q})
                 - $signed({3'b0, max_q});
  assign d_val = $signed({3'b0, max_q}) - $signed({3'b0, min_q});
  assign n_mag = n_val[18] ? 19'(-n_val) : n_val;
  assign div_num = n_mag[PRES_W-1:0];
  assign div_den = d_val[PRES_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && action_i == ACT_QUERY) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q == fill_q && !v1_q && !v2_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit && max_q > min_q && n_val < d_val && n_val > -d_val) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state_q != ST_IDLE);
    done_o    = (state_q == ST_DONE);
    div_start = (state_q == ST_DECIDE) && (state_d == ST_DIV);
  end
  assign matched_o        = res_match_q;
  assign pressure_value_o = res_val_q;

  // ring bookkeeping, scan and result datapath
  always_comb begin
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    stamp_d     = stamp_q;
    issue_d     = issue_q;
    rslot_d     = rslot_q;
    found_d     = found_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    best_pres_d = best_pres_q;
    res_match_d = res_match_q;
    res_val_d   = res_val_q;
    neg_d       = neg_q;
    mem_we      = 1'b0;
    mem_waddr   = oldest_q;
    sum         = '0;

    if (accept) begin
      unique case (action_i)
        ACT_PUSH: begin
          mem_we = 1'b1;
          if (fill_q == DEPTH_C) begin
            mem_waddr = oldest_q;
            oldest_d  = (oldest_q == AW'(FIFO_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
          end else begin
            sum       = {1'b0, oldest_q} + fill_q;
            mem_waddr = (sum >= DEPTH_C) ? AW'(sum - DEPTH_C) : sum[AW-1:0];
            fill_d    = fill_q + 1'b1;
          end
        end
        ACT_QUERY: begin
          stamp_d = stamp_ms_i;
          issue_d = '0;
          rslot_d = oldest_q;
          found_d = 1'b0;
        end
        ACT_CLEAR: begin
          fill_d   = '0;
          oldest_d = '0;
        end
        default: ;
      endcase
    end

    // read issue walks the ring
    if (issue) begin
      issue_d = issue_q + 1'b1;
      rslot_d = (rslot_q == AW'(FIFO_DEPTH - 1)) ? '0 : rslot_q + 1'b1;
    end

    // running minimum, strict compare keeps the earliest on ties
    if (v2_q && (!found_q || age2_q < best_age_q)) begin
      found_d     = 1'b1;
      best_age_d  = age2_q;
      best_idx_d  = idx2_q;
      best_pres_d = pres2_q;
    end

    if (state_q == ST_DECIDE) begin
      res_match_d = 1'b0;
      res_val_d   = '0;
      neg_d       = n_val[18];
      if (hit) begin
        sum      = {1'b0, oldest_q} + {1'b0, best_idx_q} + 1'b1;
        oldest_d = (sum >= DEPTH_C) ? AW'(sum - DEPTH_C) : sum[AW-1:0];
        fill_d   = fill_q - ({1'b0, best_idx_q} + 1'b1);
        if (max_q > min_q) begin
          res_match_d = 1'b1;
          if (n_val >= d_val) begin
            res_val_d = Q_ONE;
          end else if (n_val <= -d_val) begin
            res_val_d = 16'(-$signed(Q_ONE));
          end
        end
      end
    end

    if (state_q == ST_DIV && div_done) begin
      res_val_d = neg_q ? 16'(-$signed({2'b0, quot})) : {2'b0, quot};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      oldest_q <= '0;
      fill_q   <= '0;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      found_q  <= 1'b0;
      min_q    <= AXIS_MIN_RST;
      max_q    <= AXIS_MAX_RST;
      win_q    <= WINDOW_RST;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      fill_q   <= fill_d;
      issue_q  <= issue_d;
      v1_q     <= issue;
      v2_q     <= v1_q;
      found_q  <= found_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_AXIS_MIN: min_q <= cfg_data_i[PRES_W-1:0];
          CFG_AXIS_MAX: max_q <= cfg_data_i[PRES_W-1:0];
          CFG_WINDOW:   win_q <= cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stamp_q     <= stamp_d;
    rslot_q     <= rslot_d;
    idx1_q      <= issue_q[AW-1:0];
    idx2_q      <= idx1_q;
    age2_q      <= age;
    pres2_q     <= mem_rdata[PRES_W-1:0];
    best_age_q  <= best_age_d;
    best_idx_q  <= best_idx_d;
    best_pres_q <= best_pres_d;
    res_match_q <= res_match_d;
    res_val_q   <= res_val_d;
    neg_q       <= neg_d;
  end

  // checks
  `NTSM_NEVER(a_fill_range, clk_i, rst_ni, fill_q > DEPTH_C)
  `NTSM_ASSERT(a_query_busy, clk_i, rst_ni, (start && !busy && action_i == ACT_QUERY) |=> busy)
  `NTSM_ASSERT(a_done_from_busy, clk_i, rst_ni, done_o |-> $past(busy))
  `NTSM_NEVER(a_scan_no_write, clk_i, rst_ni, mem_we && state_q != ST_IDLE)
endmodule
